[src/pcf_pkg.sv]
// Palette colour fade package: format codes, stage payload types.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcf_pkg;

	typedef logic [1:0] fmt_t;

	localparam fmt_t FMT_3BIT = 2'd0;
	localparam fmt_t FMT_4BIT = 2'd1;
	localparam fmt_t FMT_8BIT = 2'd2;

	localparam fmt_t FMT_RESET = FMT_4BIT;

	localparam logic [8:0] POS_ONE = 9'h100;
	localparam logic [3:0] LEVEL4_MAX = 4'hF;

	// stage 1: unpacked channels, index 0 blue, 1 green, 2 red
	typedef struct packed {
		fmt_t            fmt;
		logic [2:0][7:0] a;
		logic [2:0][7:0] b;
		logic [8:0]      pos;
		logic            last;
	} s1_t;

	// stage 2: products (tgt - src) * pos, signed
	typedef struct packed {
		fmt_t             fmt;
		logic [2:0][7:0]  a;
		logic [2:0][17:0] prod;
		logic             last;
	} s2_t;

	typedef struct packed {
		logic [31:0] faded;
		logic        last;
	} s3_t;

endpackage

`default_nettype wire

[src/pcf_if.sv]
// Valid/ready channel interfaces for the palette colour fade block.
// No dependencies.
`default_nettype none

interface pcf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_colour;
	logic [31:0] target_colour;
	logic [15:0] fade_position;
	logic        last_colour;

	modport source (output valid, source_colour, target_colour, fade_position, last_colour,
		input ready);
	modport sink (input valid, source_colour, target_colour, fade_position, last_colour,
		output ready);
endinterface

interface pcf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] faded_colour;
	logic        last_out;

	modport source (output valid, faded_colour, last_out, input ready);
	modport sink (input valid, faded_colour, last_out, output ready);
endinterface

`default_nettype wire

[src/palette_colour_fade.sv]
// Palette colour fade top level: format register and three-stage pipeline.
// Depends on pcf_pkg, pcf_if, pcf_unpack, pcf_blend, pcf_pack.
//
// Usage:
//   fade_in carries one beat per palette colour: source and target colour in
//   the packed format chosen by colour_format, an 8.8 fade position (values
//   above 0x100 act as 0x100) and a last flag. fade_out returns the blended
//   colour and the copied flag, one beat per input beat, in order.
//   cfg_wr_en/cfg_wr_data write colour_format (0 3-bit, 1 rotated 4-bit,
//   2 or 3 8-bit); write it only while no beat is in flight.
//   A beat passes through three registered stages, in order: unpack,
//   multiply, shift/pack. Throughput: one beat per cycle while fade_out
//   takes beats; every stage takes a new beat as it passes its beat on.
//   When fade_out stalls, the pipeline holds and fills up; fade_in.ready
//   drops only when all three stages hold a beat. Nothing is lost.
//   Reset (arst_n low) empties the pipeline and sets colour_format to 1.
`default_nettype none

module palette_colour_fade
	import pcf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	pcf_in_if.sink          fade_in,
	pcf_out_if.source       fade_out
);

	fmt_t colour_format_q;
	logic en1, en2, en3;
	logic valid_s1, valid_s2, valid_s3;
	s1_t  data_s1;
	s2_t  data_s2;
	s3_t  data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_format_q <= FMT_RESET;
		end else if (cfg_wr_en) begin
			colour_format_q <= cfg_wr_data;
		end
	end

	assign en3 = !valid_s3 || fade_out.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign fade_in.ready = en1;

	pcf_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en1),
		.valid         (fade_in.valid),
		.fmt           (colour_format_q),
		.source_colour (fade_in.source_colour),
		.target_colour (fade_in.target_colour),
		.fade_position (fade_in.fade_position),
		.last_colour   (fade_in.last_colour),
		.valid_s1      (valid_s1),
		.data_s1       (data_s1)
	);

	pcf_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	pcf_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	assign fade_out.valid        = valid_s3;
	assign fade_out.faded_colour = data_s3.faded;
	assign fade_out.last_out     = data_s3.last;

`ifndef ASSERT_OFF
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fade_out.ready |-> fade_in.ready)
		else $error("input stalled while output is drained");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!fade_in.ready |-> valid_s1 && valid_s2 && valid_s3 && !fade_out.ready)
		else $error("input stalled with room in the pipeline");
	a_beat_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		fade_in.valid && fade_in.ready && fade_out.ready |=> valid_s1)
		else $error("accepted beat missing from stage 1");
`endif

endmodule

`default_nettype wire

[src/pcf_unpack.sv]
// Stage 1: extracts the three channels in the selected format, saturates position.
// Depends on pcf_pkg.
`default_nettype none

module pcf_unpack
	import pcf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        valid,
	input  wire fmt_t        fmt,
	input  wire logic [31:0] source_colour,
	input  wire logic [31:0] target_colour,
	input  wire logic [15:0] fade_position,
	input  wire logic        last_colour,
	output logic             valid_s1,
	output s1_t              data_s1
);

	s1_t d;

	function automatic logic [7:0] chan(input fmt_t f, input logic [31:0] c, input int k);
		logic [3:0] n;
		logic [7:0] r;
		n = c[4*k +: 4];
		case (f)
			FMT_3BIT: r = {5'd0, n[2:0]};
			FMT_4BIT: r = {4'd0, n[2:0], n[3]};
			default:  r = (k == 0) ? c[7:0] : ((k == 1) ? c[23:16] : c[31:24]);
		endcase
		return r;
	endfunction

	always_comb begin
		d.fmt  = fmt;
		d.last = last_colour;
		d.pos  = (fade_position > 16'(POS_ONE)) ? POS_ONE : fade_position[8:0];
		for (int k = 0; k < 3; k++) begin
			d.a[k] = chan(fmt, source_colour, k);
			d.b[k] = chan(fmt, target_colour, k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid) begin
			data_s1 <= d;
		end
	end

endmodule

`default_nettype wire

[src/pcf_blend.sv]
// Stage 2: per-channel signed product (tgt - src) * pos.
// Depends on pcf_pkg.
`default_nettype none

module pcf_blend
	import pcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s1,
	input  wire s1_t  data_s1,
	output logic      valid_s2,
	output s2_t       data_s2
);

	s2_t d;

	always_comb begin
		logic signed [8:0]  diff;
		logic signed [9:0]  posv;
		logic signed [18:0] p;
		d.fmt  = data_s1.fmt;
		d.a    = data_s1.a;
		d.last = data_s1.last;
		posv   = signed'({1'b0, data_s1.pos});
		for (int k = 0; k < 3; k++) begin
			diff      = signed'({1'b0, data_s1.b[k]}) - signed'({1'b0, data_s1.a[k]});
			p         = diff * posv;
			d.prod[k] = p[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2 <= d;
		end
	end

endmodule

`default_nettype wire

[src/pcf_pack.sv]
// Stage 3: floor shift, add, wrap or clamp, repack; this is the output register.
// Depends on pcf_pkg.
`default_nettype none

module pcf_pack
	import pcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s2,
	input  wire s2_t  data_s2,
	output logic      valid_s3,
	output s3_t       data_s3
);

	s3_t d;

	always_comb begin
		logic signed [9:0] r;
		logic [2:0][7:0]   lv;
		logic [3:0]        c;
		for (int k = 0; k < 3; k++) begin
			// prod[17:8] is an arithmetic shift: floor of prod / 256
			r = signed'({2'b00, data_s2.a[k]}) + signed'(data_s2.prod[k][17:8]);
			if (r[9]) begin
				c = 4'd0;
			end else if (r[8:0] > 9'(LEVEL4_MAX)) begin
				c = LEVEL4_MAX;
			end else begin
				c = r[3:0];
			end
			case (data_s2.fmt)
				FMT_3BIT: lv[k] = {5'd0, r[2:0]};
				FMT_4BIT: lv[k] = {4'd0, c[0], c[3:1]};
				default:  lv[k] = r[7:0];
			endcase
		end
		case (data_s2.fmt)
			FMT_3BIT: d.faded = {21'd0, lv[2][2:0], 1'b0, lv[1][2:0], 1'b0, lv[0][2:0]};
			FMT_4BIT: d.faded = {20'd0, lv[2][3:0], lv[1][3:0], lv[0][3:0]};
			default:  d.faded = {lv[2], lv[1], 8'd0, lv[0]};
		endcase
		d.last = data_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			data_s3 <= d;
		end
	end

`ifndef ASSERT_OFF
	a_fmt3_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 && data_s2.fmt == FMT_3BIT |=>
		data_s3.faded[31:11] == 21'd0 && !data_s3.faded[7] && !data_s3.faded[3])
		else $error("3-bit beat has bits set outside its channels");
	a_fmt4_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 && data_s2.fmt == FMT_4BIT |=> data_s3.faded[31:12] == 20'd0)
		else $error("4-bit beat has bits set above bit 11");
	a_fmt8_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 && data_s2.fmt != FMT_3BIT && data_s2.fmt != FMT_4BIT |=>
		data_s3.faded[15:8] == 8'd0)
		else $error("8-bit beat has bits set in the unused byte");
`endif

endmodule

`default_nettype wire

[sim/palette_colour_fade_tb.sv]
// Testbench for palette_colour_fade: directed table then random palettes per format.
// Uses pcf_pkg and the pcf_in_if/pcf_out_if channels; checks every beat in order.
`timescale 1ns / 100ps

module palette_colour_fade_tb;
	import pcf_pkg::*;

	localparam fmt_t FMT_8BIT_ALT = 2'd3;
	localparam fmt_t FORMAT_SWEEP [4] = '{FMT_3BIT, FMT_4BIT, FMT_8BIT, FMT_8BIT_ALT};
	localparam int PALETTE_BEATS = 105;
	localparam int HOLD_OFF_CYCLES = 64;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] tgt;
		logic [15:0] pos;
		logic        last;
	} colour_item_t;

	typedef struct packed {
		logic [31:0] colour;
		logic        last;
	} faded_beat_t;

	typedef struct packed {
		fmt_t         fmt;
		colour_item_t item;
		logic         typed;
		logic [31:0]  want;
	} directed_row_t;

	// typed rows: position 0 gives the source, position >= 1.0 gives the target (masked)
	localparam directed_row_t DIRECTED_ROWS [19] = '{
		'{FMT_4BIT, '{32'h0000_0000, 32'h0000_0FFF, 16'h0000, 1'b0}, 1'b1, 32'h0000_0000},
		'{FMT_4BIT, '{32'h0000_0000, 32'h0000_0FFF, 16'h0100, 1'b1}, 1'b1, 32'h0000_0FFF},
		'{FMT_4BIT, '{32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b0}, 1'b1, 32'h0000_0000},
		'{FMT_4BIT, '{32'h0000_0123, 32'h0000_0ABC, 16'h0080, 1'b0}, 1'b0, 32'h0},
		'{FMT_4BIT, '{32'h0000_0FFF, 32'h0000_0000, 16'h0001, 1'b0}, 1'b0, 32'h0},
		'{FMT_4BIT, '{32'hFFFF_F000, 32'hA5A5_A5A5, 16'h0101, 1'b1}, 1'b1, 32'h0000_05A5},
		'{FMT_3BIT, '{32'h0000_0777, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'h0000_0777},
		'{FMT_3BIT, '{32'h0000_0000, 32'hFFFF_FFFF, 16'h0100, 1'b0}, 1'b1, 32'h0000_0777},
		'{FMT_3BIT, '{32'h0000_0777, 32'h0000_0000, 16'h0001, 1'b0}, 1'b0, 32'h0},
		'{FMT_3BIT, '{32'h8888_8888, 32'h0000_0123, 16'h0040, 1'b0}, 1'b0, 32'h0},
		'{FMT_3BIT, '{32'h0000_0135, 32'h0000_0642, 16'hFFFF, 1'b1}, 1'b1, 32'h0000_0642},
		'{FMT_8BIT, '{32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'hFFFF_00FF},
		'{FMT_8BIT, '{32'h0000_0000, 32'hFFFF_FFFF, 16'h0100, 1'b0}, 1'b1, 32'hFFFF_00FF},
		'{FMT_8BIT, '{32'hFF00_00FF, 32'h00FF_FF00, 16'h0080, 1'b0}, 1'b0, 32'h0},
		'{FMT_8BIT, '{32'h0000_FF00, 32'hFFFF_00FF, 16'h8000, 1'b0}, 1'b1, 32'hFFFF_00FF},
		'{FMT_8BIT, '{32'hFFFF_00FF, 32'h0000_0000, 16'h0001, 1'b1}, 1'b0, 32'h0},
		'{FMT_8BIT_ALT, '{32'h1234_5678, 32'h9ABC_DEF0, 16'h0100, 1'b0}, 1'b1, 32'h9ABC_00F0},
		'{FMT_8BIT_ALT, '{32'hFFFF_FFFF, 32'h0000_0000, 16'h00C0, 1'b1}, 1'b0, 32'h0},
		'{FMT_4BIT, '{32'h0000_00F0, 32'h0000_080F, 16'h00FF, 1'b1}, 1'b0, 32'h0}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;

	pcf_in_if  in_ch ();
	pcf_out_if out_ch ();

	palette_colour_fade u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fade_in    (in_ch),
		.fade_out   (out_ch)
	);

	faded_beat_t pending_fades [$];
	fmt_t        fmt_now = FMT_RESET;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	bit          hold_off_req = 1'b0;
	int          mismatch_count = 0;
	int          beats_sent = 0;
	int          beats_checked = 0;
	int          format_writes = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] blend_colour(fmt_t fmt, logic [31:0] s, logic [31:0] t,
		logic [15:0] p);
		int          pos;
		int          sh;
		int          a;
		int          b;
		int          r;
		logic [3:0]  nib_a;
		logic [3:0]  nib_b;
		logic [31:0] res;
		pos = (p > POS_ONE) ? int'(POS_ONE) : int'(p);
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			case (fmt)
				FMT_3BIT: begin
					sh = ch * 4;
					a = int'(s[sh +: 3]);
					b = int'(t[sh +: 3]);
					r = a + (((b - a) * pos) >>> 8);
					res[sh +: 3] = r[2:0];
				end
				FMT_4BIT: begin
					sh = ch * 4;
					nib_a = s[sh +: 4];
					nib_b = t[sh +: 4];
					a = int'({nib_a[2:0], nib_a[3]});
					b = int'({nib_b[2:0], nib_b[3]});
					r = a + (((b - a) * pos) >>> 8);
					if (r < 0) r = 0;
					if (r > int'(LEVEL4_MAX)) r = int'(LEVEL4_MAX);
					res[sh +: 4] = {r[0], r[3:1]};
				end
				default: begin
					sh = (ch == 2) ? 24 : (ch == 1) ? 16 : 0;
					a = int'(s[sh +: 8]);
					b = int'(t[sh +: 8]);
					r = a + (((b - a) * pos) >>> 8);
					res[sh +: 8] = r[7:0];
				end
			endcase
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_beat(input colour_item_t item, input logic typed, input logic [31:0] want);
		faded_beat_t exp;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.source_colour <= item.src;
		in_ch.target_colour <= item.tgt;
		in_ch.fade_position <= item.pos;
		in_ch.last_colour   <= item.last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		exp.colour = typed ? want : blend_colour(fmt_now, item.src, item.tgt, item.pos);
		exp.last = item.last;
		pending_fades.push_back(exp);
		beats_sent++;
	endtask

	task automatic drain_pipe();
		in_ch.valid <= 1'b0;
		while (pending_fades.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_format(input fmt_t f);
		drain_pipe();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		fmt_now = f;
		format_writes++;
	endtask

	// receiver: checks each beat, randomizes ready, serves long hold-off requests
	initial begin
		int          hold_off_left;
		faded_beat_t exp;
		hold_off_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (pending_fades.size() == 0) begin
					report_mismatch($sformatf("unexpected beat colour=%08h last=%b",
						out_ch.faded_colour, out_ch.last_out));
				end else begin
					exp = pending_fades.pop_front();
					beats_checked++;
					if (out_ch.faded_colour !== exp.colour)
						report_mismatch($sformatf("faded_colour got %08h want %08h",
							out_ch.faded_colour, exp.colour));
					if (out_ch.last_out !== exp.last)
						report_mismatch($sformatf("last_out got %b want %b",
							out_ch.last_out, exp.last));
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		colour_item_t item;
		int           palette_left;
		int           pick;
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		in_ch.valid         = 1'b0;
		in_ch.source_colour = '0;
		in_ch.target_colour = '0;
		in_ch.fade_position = '0;
		in_ch.last_colour   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].fmt != fmt_now)
				set_format(DIRECTED_ROWS[i].fmt);
			send_beat(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end

		// three idling modes, each swept over all four format codes
		for (int ph = 0; ph < 12; ph++) begin
			case (ph / 4)
				0: begin src_idle_pct = 16; sink_idle_pct = 82; end
				1: begin src_idle_pct = 82; sink_idle_pct = 16; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			set_format(FORMAT_SWEEP[ph % 4]);
			if (ph / 4 == 2)
				hold_off_req = 1'b1;
			palette_left = 0;
			for (int n = 0; n < PALETTE_BEATS; n++) begin
				if (palette_left == 0)
					palette_left = $urandom_range(1, 16);
				palette_left--;
				item.src = $urandom();
				item.tgt = $urandom();
				pick = $urandom_range(7);
				if (pick == 0) item.src = '0;
				if (pick == 1) item.src = '1;
				if (pick == 2) item.tgt = '0;
				if (pick == 3) item.tgt = '1;
				pick = $urandom_range(9);
				if (pick < 6)
					item.pos = 16'($urandom_range(0, 256));
				else if (pick < 8)
					item.pos = (pick == 6) ? 16'h0000 : 16'h0100;
				else
					item.pos = 16'($urandom_range(0, 65535));
				item.last = (palette_left == 0);
				send_beat(item, 1'b0, 32'h0);
			end
		end

		drain_pipe();
		repeat (4) @(posedge clk);
		$display("Ran %0d colour beats (%0d directed) over %0d format writes, all four codes.",
			beats_sent, $size(DIRECTED_ROWS), format_writes);
		$display("Compared %0d output beats under three stall mixes and a long sink hold-off.",
			beats_checked);
		if (mismatch_count == 0 && pending_fades.size() == 0) begin
			$display("palette_colour_fade verification clean");
		end else begin
			$display("palette_colour_fade verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("palette_colour_fade verification failed");
		$finish;
	end

endmodule

[filelist.f]
src/pcf_pkg.sv
src/pcf_if.sv
src/pcf_unpack.sv
src/pcf_blend.sv
src/pcf_pack.sv
src/palette_colour_fade.sv
sim/palette_colour_fade_tb.sv
